// ===== design/first_order_adrc_controller_top_assert.svh =====
// ----------------------------------------------------------------------------
// first_order_adrc_controller_top_assert.svh
// Assertion macros for the ADRC controller; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef FIRST_ORDER_ADRC_CONTROLLER_TOP_ASSERT_SVH
`define FIRST_ORDER_ADRC_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, off during reset
`define FADRC_ASSERT_IMP(name_, clk_, rstn_, pre_, post_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) (pre_) |-> (post_)) \
    else $error("fadrc: implication check failed");

// Next-cycle implication, off during reset
`define FADRC_ASSERT_NXT(name_, clk_, rstn_, pre_, post_) \
  name_: assert property (@(posedge clk_) disable iff (!rstn_) (pre_) |=> (post_)) \
    else $error("fadrc: next-cycle check failed");

`else

`define FADRC_ASSERT_IMP(name_, clk_, rstn_, pre_, post_)
`define FADRC_ASSERT_NXT(name_, clk_, rstn_, pre_, post_)

`endif

`endif

// ===== design/fadrc_pkg.sv =====
// ----------------------------------------------------------------------------
// fadrc_pkg
// Widths, reset values, codes and shared types of the ADRC controller.
// ----------------------------------------------------------------------------
`default_nettype none

package fadrc_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 32;  // Q16.16 values and gains
  localparam int unsigned STEP_W    = 24;  // step period, Q0.24
  localparam int unsigned GAIN0_W   = 31;  // plant gain b0
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = 2 * DATA_W;  // full product
  localparam int unsigned NUM_W     = 49;  // feedback numerator, signed
  localparam int unsigned MAG_W     = 48;  // numerator magnitude
  localparam int unsigned VAL_W     = 34;  // quotient incl. out-of-range marks

  // Serial units: one multiplier bit / one quotient bit per cycle
  localparam int unsigned STEPS = 32;
  localparam int unsigned CNT_W = $clog2(STEPS);

  // Register reset values
  localparam logic [STEP_W-1:0]        STEP_RST  = 24'd167772;
  localparam logic [GAIN0_W-1:0]       B0_RST    = 31'd65536;
  localparam logic [DATA_W-1:0]        BETA1_RST = 32'd13107200;
  localparam logic [DATA_W-1:0]        BETA2_RST = 32'd873791488;
  localparam logic [DATA_W-1:0]        K1_RST    = 32'd655360;
  localparam logic signed [DATA_W-1:0] CMIN_RST  = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] CMAX_RST  = 32'sh7FFF_FFFF;

  // Quotient beyond the 32-bit range
  localparam logic signed [VAL_W-1:0] V_BIG = 34'sh1_0000_0000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_PERIOD  = 3'd0,
    CFG_PLANT_GAIN   = 3'd1,
    CFG_OBS_GAIN_ONE = 3'd2,
    CFG_OBS_GAIN_TWO = 3'd3,
    CFG_FB_GAIN      = 3'd4,
    CFG_CTRL_MIN     = 3'd5,
    CFG_CTRL_MAX     = 3'd6
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAIN1,   // beta1 * e
    ST_GAIN0,   // b0 * u
    ST_GAIN2,   // beta2 * e
    ST_INT1,    // h * d1
    ST_INT2,    // h * d2
    ST_FBK,     // k1 * e2
    ST_DIV_GO,
    ST_DIV,
    ST_CLAMP
  } fadrc_state_e;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;  // unsigned operand, scanned bit by bit
    logic [DATA_W-1:0] b;  // signed operand
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [PROD_W-1:0] product;  // signed
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [MAG_W-1:0]   mag;
    logic [GAIN0_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic              ovf;   // mag * 2^16 / den >= 2^32, or den zero with mag nonzero
    logic [DATA_W-1:0] quo;   // floor(mag * 2^16 / den)
  } div_rsp_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if ((v[PROD_W-1:DATA_W-1] == '0) || (v[PROD_W-1:DATA_W-1] == '1)) begin
      r = v[DATA_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = CMIN_RST;
    end else begin
      r = CMAX_RST;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/fadrc_if.sv =====
// ----------------------------------------------------------------------------
// fadrc_if
// Valid/ready channels of the ADRC controller: sample in, control out.
// ----------------------------------------------------------------------------
`default_nettype none

interface fadrc_in_if
  import fadrc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] reference;
  logic signed [DATA_W-1:0] measurement;

  modport source (output valid, output reference, output measurement, input ready);
  modport sink   (input valid, input reference, input measurement, output ready);
endinterface

interface fadrc_out_if
  import fadrc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] control;
  logic                     clamped;

  modport source (output valid, output control, output clamped, input ready);
  modport sink   (input valid, input control, input clamped, output ready);
endinterface

`default_nettype wire

// ===== design/fadrc_mul.sv =====
// ----------------------------------------------------------------------------
// fadrc_mul
// Serial shift-add multiplier: unsigned a times signed b, one bit of a a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fadrc_mul
  import fadrc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mul_req_t req_i,
  output mul_rsp_t      rsp_o
);

  logic                     busy_q;
  logic                     done_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [DATA_W:0]   hi_q;   // running partial sum, one guard bit
  logic [DATA_W-1:0]        lo_q;   // multiplier bits out, product bits in
  logic signed [DATA_W-1:0] b_q;
  logic signed [DATA_W:0]   addend;
  logic signed [DATA_W:0]   sum;
  logic                     last;

  // Conditional add of the multiplicand
  assign addend = lo_q[0] ? {b_q[DATA_W-1], b_q} : '0;
  assign sum    = hi_q + addend;
  assign last   = (cnt_q == CNT_W'(STEPS - 1));

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Accumulator shifts right one bit per step
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      hi_q <= '0;
      lo_q <= req_i.a;
      b_q  <= $signed(req_i.b);
    end else if (busy_q) begin
      hi_q <= {sum[DATA_W], sum[DATA_W:1]};
      lo_q <= {sum[0], lo_q[DATA_W-1:1]};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.busy    = busy_q;
  assign rsp_o.product = {hi_q[DATA_W-1:0], lo_q};

endmodule

`default_nettype wire

// ===== design/fadrc_div.sv =====
// ----------------------------------------------------------------------------
// fadrc_div
// Restoring divider: floor(mag * 2^16 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fadrc_div
  import fadrc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  logic                 busy_q;
  logic                 prep_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [MAG_W-1:0]     mag_q;
  logic [GAIN0_W-1:0]   den_q;
  logic [GAIN0_W-1:0]   rem_q;
  logic [DATA_W-1:0]    sh_q;    // dividend bits out, quotient bits in
  logic                 ovf_q;
  logic                 zero_q;
  logic [GAIN0_W:0]     trial;
  logic [GAIN0_W:0]     den_x;
  logic [GAIN0_W:0]     diff;
  logic                 ge;
  logic                 last;

  // Trial subtract
  assign trial = {rem_q, sh_q[DATA_W-1]};
  assign den_x = {1'b0, den_q};
  assign diff  = trial - den_x;
  assign ge    = (trial >= den_x);
  assign last  = (cnt_q == CNT_W'(STEPS - 1));

  // Sequencing: load, range check, then the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      prep_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !prep_q && last;
      if (req_i.start) begin
        busy_q <= 1'b1;
        prep_q <= 1'b1;
        cnt_q  <= '0;
      end else if (prep_q) begin
        prep_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= req_i.mag;
      den_q <= req_i.den;
    end else if (prep_q) begin
      // quotient reaches 2^32 exactly when mag >= den * 2^16
      ovf_q  <= (mag_q != '0) && (mag_q >= {1'b0, den_q, 16'h0000});
      zero_q <= (mag_q == '0);
      rem_q  <= mag_q[MAG_W-2:16];
      sh_q   <= {mag_q[15:0], 16'h0000};
    end else if (busy_q) begin
      rem_q <= ge ? diff[GAIN0_W-1:0] : trial[GAIN0_W-1:0];
      sh_q  <= {sh_q[DATA_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.busy = busy_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quo  = zero_q ? '0 : sh_q;

endmodule

`default_nettype wire

// ===== design/first_order_adrc_controller_top.sv =====
// ----------------------------------------------------------------------------
// first_order_adrc_controller_top
// First-order linear ADRC: extended observer, proportional law, output clamp.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  (sink)  : one beat = reference and measurement, signed Q16.16.
//   out_o (source): one beat = clamped control (Q16.16) and the clamped flag.
//   cfg_*         : register writes, index 0..6, taken on any edge with
//                   cfg_we_i high; write only while no sample is in flight.
// Timing: one sample at a time. Six products run on one serial multiplier
//   in turn, then the quotient on a serial divider after its launch state.
//   in_i.ready rises again the cycle after the result is loaded into the
//   output register, so a new sample is worked on while the previous
//   result waits there.
// Stall: if the previous result is still not taken when the next one is done,
//   the block holds in its clamp stage until out_o.ready frees the register.
// Reset: registers return to their defaults; observer states and the stored
//   control are zero; no beat is pending on the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_order_adrc_controller_top_assert.svh"

module first_order_adrc_controller_top
  import fadrc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  fadrc_in_if.sink                  in_i,
  fadrc_out_if.source               out_o
);

  // Configuration
  logic [STEP_W-1:0]        step_q;
  logic [GAIN0_W-1:0]       b0_q;
  logic [DATA_W-1:0]        beta1_q;
  logic [DATA_W-1:0]        beta2_q;
  logic [DATA_W-1:0]        k1_q;
  logic signed [DATA_W-1:0] cmin_q;
  logic signed [DATA_W-1:0] cmax_q;

  // Controller state and per-sample values
  fadrc_state_e             state_q, state_d;
  logic signed [DATA_W-1:0] z1_q, z2_q, u_q;
  logic signed [DATA_W-1:0] r_q, e_q, d1_q, d2_q;
  logic signed [NUM_W-1:0]  acc_q, n_q;
  logic signed [VAL_W-1:0]  v_q;
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] ctrl_q;
  logic                     clamped_q;

  // Unit handshakes
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                     in_ready;
  logic                     in_accept;
  logic                     out_load;
  logic signed [PROD_W-1:0] prod, prod16, prod24;
  logic signed [DATA_W-1:0] e_new, e2_new;
  logic [NUM_W-1:0]         n_abs;
  logic signed [VAL_W-1:0]  quo_x, v_new;
  logic signed [VAL_W-1:0]  cmin_x, cmax_x, v_hi, v_lo;
  logic                     hit_hi, hit_lo;

  fadrc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  fadrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Handshakes
  assign in_ready    = (state_q == ST_IDLE);
  assign in_accept   = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign out_load    = (state_q == ST_CLAMP) && (!out_valid_q || out_o.ready);
  assign out_o.valid   = out_valid_q;
  assign out_o.control = ctrl_q;
  assign out_o.clamped = clamped_q;

  // Product scaling (arithmetic shift is floor)
  assign prod   = $signed(mul_rsp.product);
  assign prod16 = prod >>> 16;
  assign prod24 = prod >>> 24;

  // Observer error and feedback error
  assign e_new  = sat32(PROD_W'(z1_q) - PROD_W'(in_i.measurement));
  assign e2_new = sat32(PROD_W'(r_q) - PROD_W'(z1_q));

  // Numerator magnitude for the divider
  assign n_abs = n_q[NUM_W-1] ? NUM_W'(-n_q) : n_q;

  // Signed quotient, out-of-range marked as +-2^32
  assign quo_x = $signed({2'b00, div_rsp.quo});
  always_comb begin
    if (div_rsp.ovf) begin
      v_new = n_q[NUM_W-1] ? -V_BIG : V_BIG;
    end else begin
      v_new = n_q[NUM_W-1] ? -quo_x : quo_x;
    end
  end

  // Clamp: upper limit first, then lower
  assign cmin_x = VAL_W'(cmin_q);
  assign cmax_x = VAL_W'(cmax_q);
  assign hit_hi = (v_q > cmax_x);
  assign v_hi   = hit_hi ? cmax_x : v_q;
  assign hit_lo = (v_hi < cmin_x);
  assign v_lo   = hit_lo ? cmin_x : v_hi;

  // Sequencer: next state and unit requests
  always_comb begin
    state_d = state_q;
    mul_req = '0;
    div_req = '0;
    unique case (state_q)
      ST_IDLE: begin
        mul_req.a = beta1_q;
        mul_req.b = e_new;
        if (in_accept) begin
          mul_req.start = 1'b1;
          state_d       = ST_GAIN1;
        end
      end
      ST_GAIN1: begin
        mul_req.a = DATA_W'(b0_q);
        mul_req.b = u_q;
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_d       = ST_GAIN0;
        end
      end
      ST_GAIN0: begin
        mul_req.a = beta2_q;
        mul_req.b = e_q;
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_d       = ST_GAIN2;
        end
      end
      ST_GAIN2: begin
        mul_req.a = DATA_W'(step_q);
        mul_req.b = d1_q;
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_d       = ST_INT1;
        end
      end
      ST_INT1: begin
        mul_req.a = DATA_W'(step_q);
        mul_req.b = d2_q;
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_d       = ST_INT2;
        end
      end
      ST_INT2: begin
        mul_req.a = k1_q;
        mul_req.b = e2_new;
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_d       = ST_FBK;
        end
      end
      ST_FBK: begin
        if (mul_rsp.done) begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        div_req.start = 1'b1;
        div_req.mag   = n_abs[MAG_W-1:0];
        div_req.den   = b0_q;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RST;
      b0_q    <= B0_RST;
      beta1_q <= BETA1_RST;
      beta2_q <= BETA2_RST;
      k1_q    <= K1_RST;
      cmin_q  <= CMIN_RST;
      cmax_q  <= CMAX_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STEP_PERIOD:  step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_PLANT_GAIN:   b0_q    <= cfg_data_i[GAIN0_W-1:0];
        CFG_OBS_GAIN_ONE: beta1_q <= cfg_data_i;
        CFG_OBS_GAIN_TWO: beta2_q <= cfg_data_i;
        CFG_FB_GAIN:      k1_q    <= cfg_data_i;
        CFG_CTRL_MIN:     cmin_q  <= $signed(cfg_data_i);
        CFG_CTRL_MAX:     cmax_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Observer states, stored control and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      z1_q        <= '0;
      z2_q        <= '0;
      u_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_INT1) && mul_rsp.done) begin
        z1_q <= sat32(PROD_W'(z1_q) + prod24);
      end
      if ((state_q == ST_INT2) && mul_rsp.done) begin
        z2_q <= sat32(PROD_W'(z2_q) + prod24);
      end
      if (out_load) begin
        u_q         <= v_lo[DATA_W-1:0];
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Intermediate values and output payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      r_q <= in_i.reference;
      e_q <= e_new;
    end
    if ((state_q == ST_GAIN1) && mul_rsp.done) begin
      acc_q <= NUM_W'(PROD_W'(z2_q) - prod16);
    end
    if ((state_q == ST_GAIN0) && mul_rsp.done) begin
      d1_q <= sat32(PROD_W'(acc_q) + prod16);
    end
    if ((state_q == ST_GAIN2) && mul_rsp.done) begin
      d2_q <= sat32(-prod16);
    end
    if ((state_q == ST_FBK) && mul_rsp.done) begin
      n_q <= NUM_W'(prod16 - PROD_W'(z2_q));
    end
    if ((state_q == ST_DIV) && div_rsp.done) begin
      v_q <= v_new;
    end
    if (out_load) begin
      ctrl_q    <= v_lo[DATA_W-1:0];
      clamped_q <= hit_hi || hit_lo;
    end
  end

  // Checks
  `FADRC_ASSERT_IMP(a_mul_start_free, clk_i, rst_ni, mul_req.start, !mul_rsp.busy)
  `FADRC_ASSERT_IMP(a_div_start_free, clk_i, rst_ni, div_req.start, !div_rsp.busy)
  `FADRC_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, in_accept, state_q != ST_IDLE)
  `FADRC_ASSERT_IMP(a_result_from_clamp, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_CLAMP)
  `FADRC_ASSERT_IMP(a_z1_update_slot, clk_i, rst_ni, !$stable(z1_q), $past(state_q) == ST_INT1)

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-order ADRC controller. A cycle-free
// predictor of the observer, the feedback law and the output clamp runs on
// every accepted sample beat; each control beat is compared with the oldest
// prediction. Directed samples cover the extremes, zero plant gain, crossed
// limits, quotient overflow and a long output hold. Random phases follow
// under changing register settings, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import fadrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CFG        = 7;
  localparam int HOLD_CYCLES    = 2000;   // long output hold-off
  localparam int SETTLE_CYCLES  = 4;      // idle margin before register writes
  localparam int END_CYCLES     = 300;    // about one sample time
  localparam int WATCHDOG_LIMIT = 20000;  // quiet cycles before giving up
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_SAMPLES  = 52;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;  // no register here

  localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam longint QUO_BIG = 64'sd1 << 40;  // quotient beyond 32 bits

  typedef logic [DATA_W-1:0] cfg_words_t [NUM_CFG];

  typedef struct {
    logic signed [DATA_W-1:0] control;
    logic                     clamped;
  } ctrl_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0]    cfg_data_i;

  fadrc_in_if  in_if ();
  fadrc_out_if out_if ();

  first_order_adrc_controller_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor registers and state
  logic [STEP_W-1:0]        step_q;
  logic [GAIN0_W-1:0]       b0_q;
  logic [DATA_W-1:0]        beta1_q;
  logic [DATA_W-1:0]        beta2_q;
  logic [DATA_W-1:0]        k1_q;
  logic signed [DATA_W-1:0] cmin_q;
  logic signed [DATA_W-1:0] cmax_q;
  logic signed [DATA_W-1:0] z1_q;
  logic signed [DATA_W-1:0] z2_q;
  logic signed [DATA_W-1:0] u_q;

  ctrl_result_t control_expect_q[$];

  int err_count     = 0;
  int samples_sent  = 0;
  int checked_count = 0;
  int clamped_count = 0;
  int reg_writes    = 0;
  int quiet_cycles  = 0;

  // Receiver controls, written with nonblocking assignments by the tests
  bit rx_stall_on = 1'b0;
  int rx_hold_seq = 0;

  function automatic longint clip32(input longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // One controller step: observer update, feedback law, clamp
  function automatic ctrl_result_t predict_control(input logic signed [DATA_W-1:0] r_in,
                                                   input logic signed [DATA_W-1:0] y_in);
    longint       e, d1, d2, e2, num, den, quo, rem, v;
    ctrl_result_t res;
    e  = clip32(longint'(z1_q) - longint'(y_in));
    d1 = clip32(longint'(z2_q) - ((longint'(beta1_q) * e) >>> 16)
                + ((longint'(b0_q) * longint'(u_q)) >>> 16));
    d2 = clip32(-((longint'(beta2_q) * e) >>> 16));
    z1_q = DATA_W'(clip32(longint'(z1_q) + ((longint'(step_q) * d1) >>> 24)));
    z2_q = DATA_W'(clip32(longint'(z2_q) + ((longint'(step_q) * d2) >>> 24)));
    e2  = clip32(longint'(r_in) - longint'(z1_q));
    num = ((longint'(k1_q) * e2) >>> 16) - longint'(z2_q);
    // zero gain: out of range on the side of the numerator
    if (b0_q == '0) begin
      v = (num > 0) ? QUO_BIG : ((num < 0) ? -QUO_BIG : 64'sd0);
    end else begin
      den = longint'(b0_q);
      quo = num / den;
      rem = num % den;
      if (quo >= 65536) v = QUO_BIG;
      else if (quo <= -65536) v = -QUO_BIG;
      else v = quo * 65536 + (rem * 65536) / den;
    end
    // upper limit first, lower limit wins
    res.clamped = 1'b0;
    if (v > longint'(cmax_q)) begin
      v = longint'(cmax_q);
      res.clamped = 1'b1;
    end
    if (v < longint'(cmin_q)) begin
      v = longint'(cmin_q);
      res.clamped = 1'b1;
    end
    u_q = v[DATA_W-1:0];
    res.control = v[DATA_W-1:0];
    return res;
  endfunction

  // Predict on every accepted sample beat
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      control_expect_q.push_back(predict_control(in_if.reference, in_if.measurement));
    end
  end

  // Compare every accepted control beat with the oldest prediction
  always @(posedge clk_i) begin
    ctrl_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (control_expect_q.size() == 0) begin
        $error("unexpected control beat: control %0d, clamped %0b",
               out_if.control, out_if.clamped);
        err_count++;
      end else begin
        want = control_expect_q.pop_front();
        checked_count++;
        if (out_if.clamped) clamped_count++;
        if (out_if.control !== want.control) begin
          $error("control mismatch: expected %0d, actual %0d", want.control, out_if.control);
          err_count++;
        end
        if (out_if.clamped !== want.clamped) begin
          $error("clamped mismatch: expected %0b, actual %0b", want.clamped, out_if.clamped);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Output receiver: always ready, run-length stall pattern, or a long hold
  initial begin
    int   run_left;
    int   hold_left;
    int   hold_seen;
    logic rdy;
    out_if.ready = 1'b0;
    run_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    rdy       = 1'b1;
    forever begin
      @(posedge clk_i);
      if (rx_hold_seq != hold_seen) begin
        hold_seen = rx_hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!rx_stall_on) begin
        out_if.ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          rdy = ~rdy;
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300)
                                                 : $urandom_range(1, 8);
        end
        run_left--;
        out_if.ready <= rdy;
      end
    end
  end

  // Register write, taken at the next edge; caller lowers the enable
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_STEP_PERIOD:  step_q  = data[STEP_W-1:0];
      CFG_PLANT_GAIN:   b0_q    = data[GAIN0_W-1:0];
      CFG_OBS_GAIN_ONE: beta1_q = data;
      CFG_OBS_GAIN_TWO: beta2_q = data;
      CFG_FB_GAIN:      k1_q    = data;
      CFG_CTRL_MIN:     cmin_q  = data;
      CFG_CTRL_MAX:     cmax_q  = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  // All registers, then a write to the unused index that must be ignored
  task automatic write_settings(input cfg_words_t w);
    for (int i = 0; i < NUM_CFG; i++) begin
      cfg_write(CFG_IDX_W'(i), w[i]);
    end
    cfg_write(CFG_IDX_NONE, $urandom());
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_words_t default_settings();
    cfg_words_t w;
    w[CFG_STEP_PERIOD]  = {{(DATA_W-STEP_W){1'b0}}, STEP_RST};
    w[CFG_PLANT_GAIN]   = {{(DATA_W-GAIN0_W){1'b0}}, B0_RST};
    w[CFG_OBS_GAIN_ONE] = BETA1_RST;
    w[CFG_OBS_GAIN_TWO] = BETA2_RST;
    w[CFG_FB_GAIN]      = K1_RST;
    w[CFG_CTRL_MIN]     = CMIN_RST;
    w[CFG_CTRL_MAX]     = CMAX_RST;
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_reg(input logic [DATA_W-1:0] lo,
                                                 input logic [DATA_W-1:0] hi,
                                                 input logic [DATA_W-1:0] dflt);
    case ($urandom_range(0, 3))
      0:       return lo;
      1:       return hi;
      2:       return dflt;
      default: return $urandom();
    endcase
  endfunction

  // Gentle settings keep the loop in a working range; the rest mix in extremes
  function automatic cfg_words_t draw_settings(input bit gentle);
    cfg_words_t w;
    cfg_words_t d;
    int         lim;
    d = default_settings();
    if (gentle) begin
      w[CFG_STEP_PERIOD]  = $urandom_range(1000, 400000);
      w[CFG_PLANT_GAIN]   = $urandom_range(1 << 14, 4 << 16);
      w[CFG_OBS_GAIN_ONE] = $urandom_range(0, 400 << 16);
      w[CFG_OBS_GAIN_TWO] = $urandom_range(0, 20000 << 16);
      w[CFG_FB_GAIN]      = $urandom_range(0, 20 << 16);
      lim = $urandom_range(1, 300) << 16;
      w[CFG_CTRL_MIN] = -lim;
      w[CFG_CTRL_MAX] = $urandom_range(1, 300) << 16;
      if ($urandom_range(0, 3) == 0) begin
        w[CFG_CTRL_MIN] = CMIN_RST;
        w[CFG_CTRL_MAX] = CMAX_RST;
      end
    end else begin
      w[CFG_STEP_PERIOD]  = pick_reg(32'd1, 32'h00FF_FFFF, d[CFG_STEP_PERIOD]);
      w[CFG_PLANT_GAIN]   = pick_reg(32'd1, 32'h7FFF_FFFF, d[CFG_PLANT_GAIN]);
      w[CFG_OBS_GAIN_ONE] = pick_reg(32'd0, 32'hFFFF_FFFF, d[CFG_OBS_GAIN_ONE]);
      w[CFG_OBS_GAIN_TWO] = pick_reg(32'd0, 32'hFFFF_FFFF, d[CFG_OBS_GAIN_TWO]);
      w[CFG_FB_GAIN]      = pick_reg(32'd0, 32'hFFFF_FFFF, d[CFG_FB_GAIN]);
      w[CFG_CTRL_MIN]     = pick_reg(Q_MIN, Q_MAX, d[CFG_CTRL_MIN]);
      w[CFG_CTRL_MAX]     = pick_reg(Q_MIN, Q_MAX, d[CFG_CTRL_MAX]);
    end
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] pick_sample_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 16 << 16) - (8 << 16);
      2: begin
        case ($urandom_range(0, 3))
          0:       return Q_MAX;
          1:       return Q_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom_range(0, 400 << 16) - (200 << 16);
    endcase
  endfunction

  // Offer one sample beat and wait for it; valid stays high on return
  task automatic send_sample(input logic signed [DATA_W-1:0] r_in,
                             input logic signed [DATA_W-1:0] y_in);
    in_if.valid       <= 1'b1;
    in_if.reference   <= r_in;
    in_if.measurement <= y_in;
    do @(posedge clk_i); while (!in_if.ready);
    samples_sent++;
  endtask

  // Stop offering and wait until every predicted control has come back
  task automatic drain_controls();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (control_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Zero plant gain: zero, positive and negative numerator
  task automatic test_zero_plant_gain();
    cfg_words_t w;
    w = default_settings();
    w[CFG_PLANT_GAIN]   = '0;
    w[CFG_FB_GAIN]      = '0;
    w[CFG_OBS_GAIN_TWO] = '0;   // disturbance estimate stays at zero
    write_settings(w);
    send_sample(3 * Q_ONE, -Q_ONE);
    drain_controls();
    w[CFG_FB_GAIN] = K1_RST;
    write_settings(w);
    send_sample(10 * Q_ONE, '0);
    send_sample(-10 * Q_ONE, '0);
    drain_controls();
  endtask

  // Field extremes under the reset settings
  task automatic test_field_extremes();
    write_settings(default_settings());
    send_sample(Q_MAX, Q_MIN);
    send_sample(Q_MIN, Q_MAX);
    send_sample(Q_MAX, Q_MAX);
    send_sample(Q_MIN, Q_MIN);
    send_sample('0, '0);
    send_sample(32'sd1, -32'sd1);
    send_sample(-32'sd1, 32'sd1);
    send_sample(32'sh7FFF_0000, '0);
    drain_controls();
  endtask

  // Crossed limits give the lower one; then a narrow band
  task automatic test_limit_order();
    cfg_words_t w;
    w = default_settings();
    w[CFG_CTRL_MIN] = 5 * Q_ONE;
    w[CFG_CTRL_MAX] = -5 * Q_ONE;
    write_settings(w);
    send_sample('0, '0);
    send_sample(Q_MAX, '0);
    send_sample(Q_MIN, '0);
    drain_controls();
    w[CFG_CTRL_MIN] = -Q_ONE;
    w[CFG_CTRL_MAX] = Q_ONE;
    write_settings(w);
    send_sample('0, Q_ONE);
    send_sample(100 * Q_ONE, '0);
    send_sample(-100 * Q_ONE, '0);
    drain_controls();
  endtask

  // Smallest gain and largest feedback push the quotient past 32 bits
  task automatic test_quotient_overflow();
    cfg_words_t w;
    w = default_settings();
    w[CFG_PLANT_GAIN] = 32'd1;
    w[CFG_FB_GAIN]    = 32'hFFFF_FFFF;
    write_settings(w);
    send_sample(Q_MAX, '0);
    send_sample(Q_MIN, '0);
    send_sample('0, Q_MAX);
    drain_controls();
    w[CFG_PLANT_GAIN] = 32'h7FFF_FFFF;
    write_settings(w);
    send_sample(Q_MAX, Q_MIN);
    drain_controls();
  endtask

  // Receiver holds off while samples keep coming, so the input stalls
  task automatic test_output_hold();
    write_settings(default_settings());
    rx_stall_on <= 1'b0;
    rx_hold_seq <= rx_hold_seq + 1;
    for (int i = 0; i < 6; i++) begin
      send_sample(pick_sample_value(), pick_sample_value());
    end
    drain_controls();
  endtask

  // Sender waits for all results after each group of five samples
  task automatic test_sender_pause();
    for (int k = 0; k < 2; k++) begin
      for (int i = 0; i < 5; i++) begin
        send_sample(pick_sample_value(), pick_sample_value());
      end
      drain_controls();
    end
  endtask

  // Random samples in phases of fresh settings, bursts and stalls
  task automatic test_random_sweep();
    int                       burst_left;
    bit                       gaps_on;
    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] y_val;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_settings(draw_settings(phase % 3 != 2));
      rx_stall_on <= (phase % 4 == 1) || (phase % 4 == 2);
      gaps_on = (phase % 4 != 0);
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        if (gaps_on && burst_left == 0) begin
          in_if.valid <= 1'b0;
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
                                              : $urandom_range(1, 12)) @(posedge clk_i);
          burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        r_val = pick_sample_value();
        // tracking case: measurement close to the reference
        y_val = ($urandom_range(0, 2) == 0)
                ? r_val + ($urandom_range(0, 2 << 16) - (1 << 16))
                : pick_sample_value();
        send_sample(r_val, y_val);
      end
      drain_controls();
    end
    rx_stall_on <= 1'b0;
  endtask

  // Reset, tests in turn, verdict
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.reference   = '0;
    in_if.measurement = '0;
    step_q  = STEP_RST;
    b0_q    = B0_RST;
    beta1_q = BETA1_RST;
    beta2_q = BETA2_RST;
    k1_q    = K1_RST;
    cmin_q  = CMIN_RST;
    cmax_q  = CMAX_RST;
    z1_q    = '0;
    z2_q    = '0;
    u_q     = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_plant_gain();
    test_field_extremes();
    test_limit_order();
    test_quotient_overflow();
    test_output_hold();
    test_sender_pause();
    test_random_sweep();

    repeat (END_CYCLES) @(posedge clk_i);
    $display("Ran %0d samples, checked %0d controls (%0d at a limit), %0d register writes.",
             samples_sent, checked_count, clamped_count, reg_writes);
    $display("Covered zero gain, crossed limits, quotient overflow, a long output hold, %0d %s",
             RANDOM_PHASES, "random setting phases.");
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
